// ----- rtl/lpbse_pkg.sv -----
`timescale 1ns / 1ps

package lpbse_pkg;

  localparam int DURATION_BITS = 15;
  localparam int OUT_DUR_W     = 15;
  localparam int BYTE_W        = 8;
  localparam int NUM_LANES     = 4;
  localparam int WORD_W        = NUM_LANES * BYTE_W;
  localparam int CNT_W         = 6;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;

  localparam logic [CNT_W-1:0] RGB_BITS  = CNT_W'(24);
  localparam logic [CNT_W-1:0] RGBW_BITS = CNT_W'(32);

  localparam logic [BYTE_W-1:0]        BRIGHT_RST    = 8'hFF;
  localparam logic [DURATION_BITS-1:0] ZERO_HIGH_RST = DURATION_BITS'(4);
  localparam logic [DURATION_BITS-1:0] ZERO_LOW_RST  = DURATION_BITS'(8);
  localparam logic [DURATION_BITS-1:0] ONE_HIGH_RST  = DURATION_BITS'(8);
  localparam logic [DURATION_BITS-1:0] ONE_LOW_RST   = DURATION_BITS'(4);

  typedef enum logic [2:0] {
    REG_BRIGHTNESS = 3'd0,
    REG_LED_MODE   = 3'd1,
    REG_ZERO_HIGH  = 3'd2,
    REG_ZERO_LOW   = 3'd3,
    REG_ONE_HIGH   = 3'd4,
    REG_ONE_LOW    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [DURATION_BITS-1:0] zero_high;
    logic [DURATION_BITS-1:0] zero_low;
    logic [DURATION_BITS-1:0] one_high;
    logic [DURATION_BITS-1:0] one_low;
  } timing_t;

  // scaled pixel, msb aligned to bit 31 in either mode
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              rgbw;
    logic              last;
  } pix_t;

endpackage

// ----- rtl/led_pixel_bit_symbol_encoder_unit.sv -----
`timescale 1ns / 1ps
// channel   dir  handshake            payload
// in_       in   in_tvalid/in_tready  tdata pixel_color, tlast last_pixel
// out_      out  out_tvalid/out_tready tdata high/low ticks + bit, tlast pixel_end,
//                                     tuser frame_end
// cfg_      in   apb, pready tied high 6 registers at byte address 4*i
//
// one bit symbol per cycle from the serializer shift register while the output
// is not stalled: a pixel gives 24 symbols (rgb) or 32 (rgbw); the next pixel
// waits in a one-entry buffer, and its first symbol follows the previous last one with no gap.
// four byte lanes scale a pixel in its accept cycle, results land in the buffer.
// synchronous active-low reset empties buffer and output register, loads
// register defaults. out_tready low freezes the output register; input keeps
// flowing until the buffer is full.

module led_pixel_bit_symbol_encoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] pixel_color
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [14:0] high_ticks, [29:15] low_ticks, [30] bit_value
  output logic        out_tlast,
  output logic [0:0]  out_tuser,  // [0] frame_end
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [lpbse_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [lpbse_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [lpbse_pkg::DATA_W-1:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [lpbse_pkg::BYTE_W-1:0] bright_r;
  logic                         mode_r;
  lpbse_pkg::timing_t           timing_r;
  logic                         cfg_wr;
  lpbse_pkg::reg_idx_t          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = lpbse_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r           <= lpbse_pkg::BRIGHT_RST;
      mode_r             <= 1'b0;
      timing_r.zero_high <= lpbse_pkg::ZERO_HIGH_RST;
      timing_r.zero_low  <= lpbse_pkg::ZERO_LOW_RST;
      timing_r.one_high  <= lpbse_pkg::ONE_HIGH_RST;
      timing_r.one_low   <= lpbse_pkg::ONE_LOW_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lpbse_pkg::REG_BRIGHTNESS: bright_r <= cfg_pwdata[lpbse_pkg::BYTE_W-1:0];
        lpbse_pkg::REG_LED_MODE:   mode_r   <= cfg_pwdata[0];
        lpbse_pkg::REG_ZERO_HIGH:
          timing_r.zero_high <= cfg_pwdata[lpbse_pkg::DURATION_BITS-1:0];
        lpbse_pkg::REG_ZERO_LOW:
          timing_r.zero_low <= cfg_pwdata[lpbse_pkg::DURATION_BITS-1:0];
        lpbse_pkg::REG_ONE_HIGH:
          timing_r.one_high <= cfg_pwdata[lpbse_pkg::DURATION_BITS-1:0];
        lpbse_pkg::REG_ONE_LOW:
          timing_r.one_low <= cfg_pwdata[lpbse_pkg::DURATION_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      lpbse_pkg::REG_BRIGHTNESS: cfg_prdata = lpbse_pkg::DATA_W'(bright_r);
      lpbse_pkg::REG_LED_MODE:   cfg_prdata = lpbse_pkg::DATA_W'(mode_r);
      lpbse_pkg::REG_ZERO_HIGH:  cfg_prdata = lpbse_pkg::DATA_W'(timing_r.zero_high);
      lpbse_pkg::REG_ZERO_LOW:   cfg_prdata = lpbse_pkg::DATA_W'(timing_r.zero_low);
      lpbse_pkg::REG_ONE_HIGH:   cfg_prdata = lpbse_pkg::DATA_W'(timing_r.one_high);
      lpbse_pkg::REG_ONE_LOW:    cfg_prdata = lpbse_pkg::DATA_W'(timing_r.one_low);
      default:                   cfg_prdata = '0;
    endcase
  end

  logic [lpbse_pkg::BYTE_W-1:0] lane_byte [lpbse_pkg::NUM_LANES];

  for (genvar i = 0; i < lpbse_pkg::NUM_LANES; i++) begin : g_lane
    lpbse_lane u_lane (
      .color_byte (in_tdata[i*lpbse_pkg::BYTE_W +: lpbse_pkg::BYTE_W]),
      .brightness (bright_r),
      .scaled     (lane_byte[i])
    );
  end

  logic            buf_valid;
  logic            buf_take;
  lpbse_pkg::pix_t buf_pix;

  lpbse_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_last   (in_tlast),
    .led_mode  (mode_r),
    .lane_byte (lane_byte),
    .in_ready  (in_tready),
    .buf_valid (buf_valid),
    .buf_pix   (buf_pix),
    .buf_take  (buf_take)
  );

  logic [lpbse_pkg::OUT_DUR_W-1:0] sym_high;
  logic [lpbse_pkg::OUT_DUR_W-1:0] sym_low;
  logic                            sym_bit;

  lpbse_serializer u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .timing        (timing_r),
    .buf_valid     (buf_valid),
    .buf_pix       (buf_pix),
    .buf_take      (buf_take),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_high      (sym_high),
    .out_low       (sym_low),
    .out_bit       (sym_bit),
    .out_pixel_end (out_tlast),
    .out_frame_end (out_tuser[0])
  );

  assign out_tdata = {1'b0, sym_bit, sym_low, sym_high};

endmodule

// ----- rtl/lpbse_lane.sv -----
`timescale 1ns / 1ps

module lpbse_lane (
  input  logic [lpbse_pkg::BYTE_W-1:0] color_byte,
  input  logic [lpbse_pkg::BYTE_W-1:0] brightness,
  output logic [lpbse_pkg::BYTE_W-1:0] scaled
);

  logic [2*lpbse_pkg::BYTE_W-1:0] prod;
  logic [2*lpbse_pkg::BYTE_W:0]   sum;

  assign prod = color_byte * brightness;
  // floor(p / 255) as (p + (p >> 8) + 1) >> 8, exact for 16-bit p
  assign sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
  assign scaled = sum[15:8];

endmodule

// ----- rtl/lpbse_merge.sv -----
`timescale 1ns / 1ps

module lpbse_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_last,
  input  logic                         led_mode,
  input  logic [lpbse_pkg::BYTE_W-1:0] lane_byte [lpbse_pkg::NUM_LANES],
  output logic                         in_ready,
  output logic                         buf_valid,
  output lpbse_pkg::pix_t              buf_pix,
  input  logic                         buf_take
);

  logic            valid_r, valid_nxt;
  lpbse_pkg::pix_t pix_r, pix_nxt;

  always_comb begin
    valid_nxt = valid_r;
    pix_nxt   = pix_r;
    if (buf_take) begin
      valid_nxt = 1'b0;
    end
    if (in_valid && !valid_r) begin
      valid_nxt    = 1'b1;
      pix_nxt.last = in_last;
      pix_nxt.rgbw = led_mode;
      if (led_mode) begin
        pix_nxt.word = {lane_byte[3], lane_byte[2], lane_byte[1], lane_byte[0]};
      end else begin
        // white byte dropped, red moves to the top
        pix_nxt.word = {lane_byte[2], lane_byte[1], lane_byte[0], 8'h00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    pix_r <= pix_nxt;
  end

  assign in_ready  = !valid_r;
  assign buf_valid = valid_r;
  assign buf_pix   = pix_r;

endmodule

// ----- rtl/lpbse_serializer.sv -----
`timescale 1ns / 1ps

module lpbse_serializer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lpbse_pkg::timing_t              timing,
  input  logic                            buf_valid,
  input  lpbse_pkg::pix_t                 buf_pix,
  output logic                            buf_take,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lpbse_pkg::OUT_DUR_W-1:0] out_high,
  output logic [lpbse_pkg::OUT_DUR_W-1:0] out_low,
  output logic                            out_bit,
  output logic                            out_pixel_end,
  output logic                            out_frame_end
);

  logic [lpbse_pkg::WORD_W-1:0]    word_r, word_nxt;
  logic [lpbse_pkg::CNT_W-1:0]     left_r, left_nxt;
  logic                            last_r, last_nxt;
  logic                            valid_r, valid_nxt;
  logic [lpbse_pkg::OUT_DUR_W-1:0] high_r, high_nxt;
  logic [lpbse_pkg::OUT_DUR_W-1:0] low_r, low_nxt;
  logic                            bit_r, bit_nxt;
  logic                            pend_r, pend_nxt;
  logic                            fend_r, fend_nxt;
  logic                            adv;
  logic                            sel_bit;

  assign adv = !valid_r || out_ready;

  always_comb begin
    word_nxt  = word_r;
    left_nxt  = left_r;
    last_nxt  = last_r;
    valid_nxt = valid_r;
    bit_nxt   = bit_r;
    pend_nxt  = pend_r;
    fend_nxt  = fend_r;
    buf_take  = 1'b0;
    sel_bit   = word_r[lpbse_pkg::WORD_W-1];
    if (adv) begin
      if (left_r != '0) begin
        sel_bit   = word_r[lpbse_pkg::WORD_W-1];
        word_nxt  = word_r << 1;
        left_nxt  = left_r - 1'b1;
        valid_nxt = 1'b1;
        bit_nxt   = sel_bit;
        pend_nxt  = (left_r == lpbse_pkg::CNT_W'(1));
        fend_nxt  = (left_r == lpbse_pkg::CNT_W'(1)) && last_r;
      end else if (buf_valid) begin
        // next pixel starts in the cycle the previous one ends
        buf_take  = 1'b1;
        sel_bit   = buf_pix.word[lpbse_pkg::WORD_W-1];
        word_nxt  = buf_pix.word << 1;
        left_nxt  = (buf_pix.rgbw ? lpbse_pkg::RGBW_BITS : lpbse_pkg::RGB_BITS) - 1'b1;
        last_nxt  = buf_pix.last;
        valid_nxt = 1'b1;
        bit_nxt   = sel_bit;
        pend_nxt  = 1'b0;
        fend_nxt  = 1'b0;
      end else begin
        valid_nxt = 1'b0;
      end
    end
    high_nxt = high_r;
    low_nxt  = low_r;
    if (adv) begin
      high_nxt = lpbse_pkg::OUT_DUR_W'(sel_bit ? timing.one_high : timing.zero_high);
      low_nxt  = lpbse_pkg::OUT_DUR_W'(sel_bit ? timing.one_low : timing.zero_low);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      left_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      left_r  <= left_nxt;
    end
    word_r <= word_nxt;
    last_r <= last_nxt;
    high_r <= high_nxt;
    low_r  <= low_nxt;
    bit_r  <= bit_nxt;
    pend_r <= pend_nxt;
    fend_r <= fend_nxt;
  end

  assign out_valid     = valid_r;
  assign out_high      = high_r;
  assign out_low       = low_r;
  assign out_bit       = bit_r;
  assign out_pixel_end = pend_r;
  assign out_frame_end = fend_r;

endmodule

// ----- rtl/lpbse_checker.sv -----
`timescale 1ns / 1ps

module lpbse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic [0:0]  out_tuser
);

  // reset empties the output register
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // frame end only on the last symbol of a pixel
  a_frame_on_pixel_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("frame_end without pixel_end");

  // an accepted pixel fills the one-entry buffer
  a_buffer_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transaction");

  // stalled symbol holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled output transaction changed");

endmodule

bind led_pixel_bit_symbol_encoder_unit lpbse_checker u_lpbse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
